[design/ids_pkg.sv]
`default_nettype none

package ids_pkg;

    localparam int MAX_WIDTH_DEFAULT    = 2048;
    localparam int CHANNEL_BITS_DEFAULT = 8;

    // configuration register file
    localparam int DIM_BITS   = 12;
    localparam int INDEX_BITS = 2;
    localparam logic [INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;

    localparam int HEIGHT_LIMIT = 2048;
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);

    // stream payload
    localparam int PIX_BITS  = 8;
    localparam int NUM_CHAN  = 3;
    localparam int DATA_BITS = NUM_CHAN * PIX_BITS;

    // scan position decode for the pixel at the head of the input
    typedef struct packed {
        logic hold_left;
        logic wr_pair;
        logic rd_pair;
        logic row_end;
        logic frame_end;
    } scan_t;

    function automatic int line_addr_bits(input int max_width);
        int depth;
        depth = max_width / 2;
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

[design/image_downscale_2x_box_average_top.sv]
`default_nettype none

// Channel      Signals                                  Beat contents
// s_axis       s_axis_tvalid/tready/tdata               one RGB input pixel, raster order
// m_axis       m_axis_tvalid/tready/tdata/tlast/tuser   one averaged 2x2 block
// cfg          cfg_we/cfg_index/cfg_wdata               image width or height
//
// One input pixel per clock while s_axis_tready is high; the right pixel of each pair
// costs one line-store access, a write on even rows or a registered read on odd rows.
// A completing pixel's line-store read and pair sum go to a second stage, then the
// adder result to the output register. Reset clears counters and valids; the line
// store has no clearing pass. While m_axis stalls one result waits in the second stage,
// and s_axis keeps taking pixels that do not produce a result.
module image_downscale_2x_box_average_top #(
    parameter int MAX_WIDTH    = ids_pkg::MAX_WIDTH_DEFAULT,
    parameter int CHANNEL_BITS = ids_pkg::CHANNEL_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ids_pkg::INDEX_BITS-1:0]     cfg_index,
    input  wire logic [ids_pkg::DIM_BITS-1:0]       cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [ids_pkg::DATA_BITS-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [ids_pkg::DATA_BITS-1:0]           m_axis_tdata,  // out_red, out_green, out_blue
    output logic                                    m_axis_tlast,  // row_end
    output logic [0:0]                              m_axis_tuser   // frame_end
);

    import ids_pkg::*;

    localparam int CB         = CHANNEL_BITS;
    localparam int ADDR_BITS  = line_addr_bits(MAX_WIDTH);
    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int SUM_BITS   = CB + 1;

    scan_t                        stat;
    logic [ADDR_BITS-1:0]         slot;
    logic                         in_accept;
    logic                         out_load;
    logic                         s1_free;
    logic                         ram_we;
    logic                         ram_re;
    logic [NUM_CHAN-1:0][CB-1:0]  px;
    logic [NUM_CHAN-1:0][SUM_BITS-1:0] pair;
    logic [NUM_CHAN-1:0][SUM_BITS-1:0] ram_rdata;
    logic [DATA_BITS-1:0]         out_data_next;

    logic [NUM_CHAN-1:0][CB-1:0]  held_left_reg;
    logic                         s1_valid_reg, s1_valid_next;
    logic [NUM_CHAN-1:0][SUM_BITS-1:0] s1_pair_reg;
    logic                         s1_row_end_reg;
    logic                         s1_frame_end_reg;
    logic                         m_valid_reg, m_valid_next;
    logic [DATA_BITS-1:0]         m_data_reg;
    logic                         m_last_reg;
    logic                         m_user_reg;

    ids_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (in_accept),
        .stat      (stat),
        .slot      (slot)
    );

    ids_ram #(
        .WIDTH (NUM_CHAN * SUM_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (pair),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_load      = s1_valid_reg && (!m_valid_reg || m_axis_tready);
        s1_free       = !s1_valid_reg || out_load;
        // only a beat that completes a block needs room in the second stage
        s_axis_tready = !stat.rd_pair || s1_free;
        in_accept     = s_axis_tvalid && s_axis_tready;
        ram_we        = in_accept && stat.wr_pair;
        ram_re        = in_accept && stat.rd_pair;
    end

    always_comb
    begin
        logic [CB+PIX_BITS-1:0]   in_ext;
        logic [SUM_BITS:0]        sum;
        logic [CB+PIX_BITS-1:0]   avg_ext;
        out_data_next = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            // drop channel bits above CHANNEL_BITS
            in_ext  = {{CB{1'b0}}, s_axis_tdata[PIX_BITS*c +: PIX_BITS]};
            px[c]   = in_ext[CB-1:0];
            pair[c] = {1'b0, held_left_reg[c]} + {1'b0, px[c]};
            sum     = {1'b0, ram_rdata[c]} + {1'b0, s1_pair_reg[c]} + (SUM_BITS + 1)'(2);
            avg_ext = {{PIX_BITS{1'b0}}, sum[SUM_BITS:2]};
            out_data_next[PIX_BITS*c +: PIX_BITS] = avg_ext[PIX_BITS-1:0];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ram_re)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            held_left_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (in_accept && stat.hold_left)
            begin
                held_left_reg <= px;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_pair_reg      <= pair;
            s1_row_end_reg   <= stat.row_end;
            s1_frame_end_reg <= stat.frame_end;
        end
        if (out_load)
        begin
            m_data_reg <= out_data_next;
            m_last_reg <= s1_row_end_reg;
            m_user_reg <= s1_frame_end_reg;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tlast    = m_last_reg;
    assign m_axis_tuser[0] = m_user_reg;

`ifndef SYNTHESIS
    // a completing beat always lands in the second stage
    a_rd_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> s1_valid_reg)
        else $error("completing beat did not reach second stage");

    // the line-store read data must not be overwritten while a result waits on it
    a_rd_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> s1_free)
        else $error("line-store read issued while second stage is blocked");

    // beats that complete no block are never held off
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.rd_pair |-> s_axis_tready)
        else $error("input stalled on a beat with no result");

    // a stalled second stage holds its flags
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_row_end_reg)
            && $stable(s1_frame_end_reg))
        else $error("second stage lost its result while stalled");

    // output flags follow the stage they came from
    a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid && (m_axis_tlast == $past(s1_row_end_reg))
            && (m_axis_tuser[0] == $past(s1_frame_end_reg)))
        else $error("output flags do not match second stage");
`endif

endmodule

`default_nettype wire

[design/ids_ram.sv]
`default_nettype none

module ids_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/ids_scan.sv]
`default_nettype none

module ids_scan #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_we,
    input  wire logic [ids_pkg::INDEX_BITS-1:0]           cfg_index,
    input  wire logic [ids_pkg::DIM_BITS-1:0]             cfg_wdata,
    input  wire logic                                     advance,
    output ids_pkg::scan_t                                stat,
    output logic [ids_pkg::line_addr_bits(MAX_WIDTH)-1:0] slot
);

    import ids_pkg::*;

    localparam int ADDR_BITS  = line_addr_bits(MAX_WIDTH);
    localparam int COL_BITS   = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int WCL_BITS   = ($clog2(MAX_WIDTH + 1) > DIM_BITS) ?
                                $clog2(MAX_WIDTH + 1) : DIM_BITS;
    localparam int HCL_BITS   = DIM_BITS;

    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] col_last_reg, col_last_next;
    logic [COL_BITS-1:0] col_pair_last_reg, col_pair_last_next;
    logic                col_pair_ok_reg, col_pair_ok_next;
    logic [ROW_BITS-1:0] row_last_reg, row_last_next;
    logic [ROW_BITS-1:0] row_pair_last_reg, row_pair_last_next;
    logic                row_pair_ok_reg, row_pair_ok_next;
    logic                in_col, in_row;

    function automatic logic [WCL_BITS-1:0] clamp_width(input logic [DIM_BITS-1:0] v);
        logic [WCL_BITS-1:0] vz;
        vz = (v == '0) ? WCL_BITS'(1) : WCL_BITS'(v);
        return (vz > WCL_BITS'(MAX_WIDTH)) ? WCL_BITS'(MAX_WIDTH) : vz;
    endfunction

    function automatic logic [HCL_BITS-1:0] clamp_height(input logic [DIM_BITS-1:0] v);
        logic [HCL_BITS-1:0] vz;
        vz = (v == '0) ? HCL_BITS'(1) : v;
        return (vz > HCL_BITS'(HEIGHT_LIMIT)) ? HCL_BITS'(HEIGHT_LIMIT) : vz;
    endfunction

    function automatic logic [COL_BITS-1:0] width_last(input logic [DIM_BITS-1:0] v);
        logic [WCL_BITS-1:0] w;
        w = clamp_width(v);
        return COL_BITS'(w - WCL_BITS'(1));
    endfunction

    // right pixel column of the last complete pair
    function automatic logic [COL_BITS-1:0] width_pair_last(input logic [DIM_BITS-1:0] v);
        logic [WCL_BITS-1:0] w;
        w = clamp_width(v);
        return COL_BITS'({w[WCL_BITS-1:1], 1'b0} - WCL_BITS'(1));
    endfunction

    function automatic logic width_pair_ok(input logic [DIM_BITS-1:0] v);
        logic [WCL_BITS-1:0] w;
        w = clamp_width(v);
        return (w[WCL_BITS-1:1] != '0);
    endfunction

    function automatic logic [ROW_BITS-1:0] height_last(input logic [DIM_BITS-1:0] v);
        logic [HCL_BITS-1:0] h;
        h = clamp_height(v);
        return ROW_BITS'(h - HCL_BITS'(1));
    endfunction

    function automatic logic [ROW_BITS-1:0] height_pair_last(input logic [DIM_BITS-1:0] v);
        logic [HCL_BITS-1:0] h;
        h = clamp_height(v);
        return ROW_BITS'({h[HCL_BITS-1:1], 1'b0} - HCL_BITS'(1));
    endfunction

    function automatic logic height_pair_ok(input logic [DIM_BITS-1:0] v);
        logic [HCL_BITS-1:0] h;
        h = clamp_height(v);
        return (h[HCL_BITS-1:1] != '0);
    endfunction

    always_comb
    begin
        col_next           = col_reg;
        row_next           = row_reg;
        col_last_next      = col_last_reg;
        col_pair_last_next = col_pair_last_reg;
        col_pair_ok_next   = col_pair_ok_reg;
        row_last_next      = row_last_reg;
        row_pair_last_next = row_pair_last_reg;
        row_pair_ok_next   = row_pair_ok_reg;

        if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT))
        begin
            // a write to the width or height register restarts the frame
            col_next = '0;
            row_next = '0;
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                col_last_next      = width_last(cfg_wdata);
                col_pair_last_next = width_pair_last(cfg_wdata);
                col_pair_ok_next   = width_pair_ok(cfg_wdata);
            end
            else
            begin
                row_last_next      = height_last(cfg_wdata);
                row_pair_last_next = height_pair_last(cfg_wdata);
                row_pair_ok_next   = height_pair_ok(cfg_wdata);
            end
        end
        else if (advance)
        begin
            if (col_reg == col_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == row_last_reg) ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg           <= '0;
            row_reg           <= '0;
            col_last_reg      <= width_last(WIDTH_RESET);
            col_pair_last_reg <= width_pair_last(WIDTH_RESET);
            col_pair_ok_reg   <= width_pair_ok(WIDTH_RESET);
            row_last_reg      <= height_last(HEIGHT_RESET);
            row_pair_last_reg <= height_pair_last(HEIGHT_RESET);
            row_pair_ok_reg   <= height_pair_ok(HEIGHT_RESET);
        end
        else
        begin
            col_reg           <= col_next;
            row_reg           <= row_next;
            col_last_reg      <= col_last_next;
            col_pair_last_reg <= col_pair_last_next;
            col_pair_ok_reg   <= col_pair_ok_next;
            row_last_reg      <= row_last_next;
            row_pair_last_reg <= row_pair_last_next;
            row_pair_ok_reg   <= row_pair_ok_next;
        end
    end

    always_comb
    begin
        in_col = col_pair_ok_reg && (col_reg <= col_pair_last_reg);
        in_row = row_pair_ok_reg && (row_reg <= row_pair_last_reg);

        stat.hold_left = in_col && in_row && !col_reg[0];
        stat.wr_pair   = in_col && in_row && col_reg[0] && !row_reg[0];
        stat.rd_pair   = in_col && in_row && col_reg[0] && row_reg[0];
        stat.row_end   = (col_reg == col_pair_last_reg);
        stat.frame_end = (col_reg == col_pair_last_reg) && (row_reg == row_pair_last_reg);

        slot = col_reg[ADDR_BITS:1];
    end

endmodule

`default_nettype wire

[bench/downscale_checker.sv]
module downscale_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ids_pkg::INDEX_BITS-1:0]      cfg_index,
    input  logic [ids_pkg::DIM_BITS-1:0]        cfg_wdata,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ids_pkg::DATA_BITS-1:0]       s_axis_tdata,  // in_red, in_green, in_blue
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ids_pkg::DATA_BITS-1:0]       m_axis_tdata,  // out_red, out_green, out_blue
    input  logic                                m_axis_tlast,  // row_end
    input  logic [0:0]                          m_axis_tuser,  // frame_end
    output int unsigned                         error_count,
    output int unsigned                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB         = ids_pkg::PIX_BITS;
    localparam int LINE_SLOTS = ids_pkg::MAX_WIDTH_DEFAULT / 2;

    typedef struct packed {
        logic [PB-1:0] blue;
        logic [PB-1:0] green;
        logic [PB-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [PB:0] blue;
        logic [PB:0] green;
        logic [PB:0] red;
    } pair_sum_t;

    typedef struct packed {
        logic [PB-1:0] red;
        logic [PB-1:0] green;
        logic [PB-1:0] blue;
        logic          row_end;
        logic          frame_end;
    } block_avg_t;

    logic [ids_pkg::DIM_BITS-1:0] width_reg;
    logic [ids_pkg::DIM_BITS-1:0] height_reg;
    pair_sum_t                    pair_line [LINE_SLOTS];
    rgb_t                         held_px;
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    block_avg_t                   expected_blocks [$];

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // round half up: (upper pair + lower pair + 2) / 4
    function automatic logic [PB-1:0] box_avg(input logic [PB:0] upper, input logic [PB:0] lower);
        logic [PB+1:0] total;
        total = upper + lower + 2'd2;
        return total[PB+1:2];
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned w, h, out_w, out_h, slot;
        rgb_t        px;
        rgb_t        got_px;
        pair_sum_t   pair;
        pair_sum_t   stored;
        block_avg_t  want;
        if (!rst_n)
        begin
            width_reg   = ids_pkg::WIDTH_RESET;
            height_reg  = ids_pkg::HEIGHT_RESET;
            held_px     = '0;
            col_pos     = 0;
            row_pos     = 0;
            expected_blocks.delete();
            error_count = 0;
            pending     = 0;
        end
        else
        begin
            // a register write restarts the frame; spare indexes leave the scan alone
            if (cfg_we && cfg_index == ids_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg = cfg_wdata;
                col_pos   = 0;
                row_pos   = 0;
            end
            else if (cfg_we && cfg_index == ids_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg = cfg_wdata;
                col_pos    = 0;
                row_pos    = 0;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                px    = s_axis_tdata;
                w     = clamp_dim(width_reg, ids_pkg::MAX_WIDTH_DEFAULT);
                h     = clamp_dim(height_reg, ids_pkg::HEIGHT_LIMIT);
                out_w = w / 2;
                out_h = h / 2;
                // trailing odd column or row is consumed without effect
                if (col_pos < 2 * out_w && row_pos < 2 * out_h)
                begin
                    if (col_pos[0] == 1'b0)
                        held_px = px;
                    else
                    begin
                        slot       = col_pos >> 1;
                        pair.red   = held_px.red + px.red;
                        pair.green = held_px.green + px.green;
                        pair.blue  = held_px.blue + px.blue;
                        if (row_pos[0] == 1'b0)
                            pair_line[slot] = pair;
                        else
                        begin
                            stored         = pair_line[slot];
                            want.red       = box_avg(stored.red, pair.red);
                            want.green     = box_avg(stored.green, pair.green);
                            want.blue      = box_avg(stored.blue, pair.blue);
                            want.row_end   = (slot == out_w - 1);
                            want.frame_end = want.row_end && ((row_pos >> 1) == out_h - 1);
                            expected_blocks.push_back(want);
                        end
                    end
                end
                col_pos++;
                if (col_pos >= w)
                begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos >= h)
                        row_pos = 0;
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got_px = m_axis_tdata;
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t: result beat with none expected, got %h last %b user %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    check_field("out_red", want.red, got_px.red);
                    check_field("out_green", want.green, got_px.green);
                    check_field("out_blue", want.blue, got_px.blue);
                    check_field("row_end", want.row_end, m_axis_tlast);
                    check_field("frame_end", want.frame_end, m_axis_tuser[0]);
                end
            end
            pending = expected_blocks.size();
        end
    end

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PX_BITS          = ids_pkg::DATA_BITS;
    localparam int DIM_BITS         = ids_pkg::DIM_BITS;
    localparam int SETTLE_CYCLES    = 6;
    localparam int PIXELS_PER_PHASE = 190;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_CYCLES       = 1_000_000;

    // indexes with no register behind them
    localparam logic [ids_pkg::INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [ids_pkg::INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              cfg_we        = 1'b0;
    logic [ids_pkg::INDEX_BITS-1:0]    cfg_index     = '0;
    logic [DIM_BITS-1:0]               cfg_wdata     = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [PX_BITS-1:0]                s_axis_tdata  = '0;  // in_red, in_green, in_blue
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [PX_BITS-1:0]                m_axis_tdata;        // out_red, out_green, out_blue
    logic                              m_axis_tlast;        // row_end
    logic [0:0]                        m_axis_tuser;        // frame_end

    int unsigned mismatches;
    int unsigned pending;
    int unsigned src_idle_pct = 17;
    int unsigned dst_idle_pct = 85;
    bit          hold_req     = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned cur_w        = ids_pkg::WIDTH_RESET;
    int unsigned cur_h        = ids_pkg::HEIGHT_RESET;

    // 4x4 frame: black/white blocks, tiny sums for rounding, midscale sums
    logic [PX_BITS-1:0] grid_4x4 [16] = '{
        24'h000000, 24'hFFFFFF, 24'h010000, 24'h000102,
        24'hFFFFFF, 24'h000000, 24'h000100, 24'h020100,
        24'hFFFFFF, 24'hFFFFFF, 24'h808080, 24'h7F7F7F,
        24'hFFFFFF, 24'hFFFFFF, 24'h010101, 24'h000000
    };

    image_downscale_2x_box_average_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    downscale_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (mismatches),
        .pending       (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random backpressure, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic write_reg(input logic [ids_pkg::INDEX_BITS-1:0] idx,
                             input logic [DIM_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        // track only what the random frames need; their sizes never saturate
        if (idx == ids_pkg::REG_IMAGE_WIDTH)
            cur_w = (val == 0) ? 1 : val;
        else if (idx == ids_pkg::REG_IMAGE_HEIGHT)
            cur_h = (val == 0) ? 1 : val;
    endtask

    // leave tvalid high after the beat so back-to-back pixels need no toggle
    task automatic push_pixel(input logic [PX_BITS-1:0] px);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count)
            push_pixel(PX_BITS'($urandom()));
    endtask

    // drop tvalid, wait for every expected beat, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [DIM_BITS-1:0] pick_dim(input int unsigned hi);
        if ($urandom_range(99) < 12)
            return DIM_BITS'($urandom_range(2));
        return DIM_BITS'($urandom_range(hi, 1));
    endfunction

    initial
    begin
        int unsigned phase;
        int unsigned fed;
        int unsigned n;
        int unsigned choice;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry is 640x480: a few pixels give nothing
        send_pixels(4);
        settle();

        write_reg(ids_pkg::REG_IMAGE_WIDTH, 4);
        write_reg(ids_pkg::REG_IMAGE_HEIGHT, 4);
        for (int i = 0; i < 16; i++)
            push_pixel(grid_4x4[i]);
        settle();

        // odd sizes: trailing column and row dropped, single block per frame
        write_reg(ids_pkg::REG_IMAGE_WIDTH, 3);
        write_reg(ids_pkg::REG_IMAGE_HEIGHT, 3);
        send_pixels(9);

        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 85 : 0;
            dst_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 17 : 0;
            fed = 0;
            while (fed < PIXELS_PER_PHASE)
            begin
                settle();
                choice = $urandom_range(99);
                if (choice < 8)
                    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                              DIM_BITS'($urandom()));
                else
                begin
                    if ($urandom_range(99) < 70)
                        write_reg(ids_pkg::REG_IMAGE_WIDTH, pick_dim(12));
                    if ($urandom_range(99) < 70)
                        write_reg(ids_pkg::REG_IMAGE_HEIGHT, pick_dim(6));
                end
                // mostly whole frames, some doubled, some cut short
                n = cur_w * cur_h;
                choice = $urandom_range(99);
                if (choice < 15)
                    n = 2 * n;
                else if (choice < 30)
                    n = $urandom_range(n, 1);
                send_pixels(n);
                fed += n;
            end
        end

        // long receiver hold-off while pixels keep coming
        settle();
        write_reg(ids_pkg::REG_IMAGE_WIDTH, 8);
        write_reg(ids_pkg::REG_IMAGE_HEIGHT, 16);
        hold_req = 1'b1;
        send_pixels(128);
        settle();

        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
design/ids_pkg.sv
design/ids_ram.sv
design/ids_scan.sv
design/image_downscale_2x_box_average_top.sv
bench/downscale_checker.sv
bench/tb.sv
